### hw/rtl/tmr_tbl_pkg.sv
package tmr_tbl_pkg;

    // command codes
    localparam logic [2:0] CMD_SET_SHOT     = 3'd0;
    localparam logic [2:0] CMD_CANCEL_ID    = 3'd1;
    localparam logic [2:0] CMD_CANCEL_OWNER = 3'd2;
    localparam logic [2:0] CMD_START_PER    = 3'd3;
    localparam logic [2:0] CMD_STOP_PER     = 3'd4;
    localparam logic [2:0] CMD_POLL         = 3'd5;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // one result beat
    typedef struct packed {
        logic [31:0] return_value;
        logic        fired;
        logic        fire_source;
        logic [31:0] fire_callback;
        logic [31:0] fire_arg0;
        logic [31:0] fire_arg1;
    } t_result;

    // one-shot table entry
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] owner;
        logic [31:0] deadline;
        logic [31:0] arg;
        logic [31:0] callback;
    } t_shot;

    // periodic slot entry
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] callback;
        logic [31:0] interval;
        logic [31:0] due;
    } t_slot;

    // deadline reached under 32-bit wraparound
    function automatic logic reached(input logic [31:0] now, input logic [31:0] when_t);
        logic [31:0] diff;
        diff = now - when_t;
        return ~diff[31];
    endfunction

endpackage

### hw/rtl/tmr_tbl_out_reg.sv
module tmr_tbl_out_reg
    import tmr_tbl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

endmodule

### hw/rtl/one_shot_and_periodic_timer_table.sv
// One-shot and periodic timer table. Each input beat carries one command and the
// current tick and yields exactly one result beat. One-shot timers are kept in
// insertion order in a single-port-read memory; periodic timers in a second memory
// with per-slot used flags. Each entry visited by a scan is read, then checked;
// stop/start periodic scan the periodic slots, cancel and one-shot poll scan the
// one-shot entries and move later entries down when an entry is removed, and poll
// first scans the periodic slots, stopping at the first that fires. Cancel by
// owner may remove many entries. The next command is taken while the previous
// result waits at the output.
module one_shot_and_periodic_timer_table
    import tmr_tbl_pkg::*;
#(
    parameter int ONE_SHOT_SLOTS = 16,
    parameter int PERIODIC_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_current_time,
    input  logic [31:0] i_delay,
    input  logic [31:0] i_callback,
    input  logic [31:0] i_owner_tag,
    input  logic [31:0] i_user_arg,
    input  logic [31:0] i_timer_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_return_value,
    output logic        o_fired,
    output logic        o_fire_source,
    output logic [31:0] o_fire_callback,
    output logic [31:0] o_fire_arg0,
    output logic [31:0] o_fire_arg1
);

    localparam int SW  = (ONE_SHOT_SLOTS > 1) ? $clog2(ONE_SHOT_SLOTS) : 1;
    localparam int CW  = $clog2(ONE_SHOT_SLOTS + 1);
    localparam int PW  = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
    localparam int PCW = $clog2(PERIODIC_SLOTS + 1);
    localparam int IW  = (CW > PCW) ? CW : PCW;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SET   = 4'd1;
    localparam logic [3:0] ST_P_RD  = 4'd2;
    localparam logic [3:0] ST_P_CHK = 4'd3;
    localparam logic [3:0] ST_P_NEW = 4'd4;
    localparam logic [3:0] ST_S_RD  = 4'd5;
    localparam logic [3:0] ST_S_CHK = 4'd6;
    localparam logic [3:0] ST_SH_RD = 4'd7;
    localparam logic [3:0] ST_SH_WR = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    // control registers
    logic [3:0]  r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_id_ctr, n_id_ctr;
    logic        r_active, n_active;
    logic [PERIODIC_SLOTS-1:0] r_used, n_used;

    // latched command
    logic [2:0]  r_cmd;
    logic [31:0] r_now, r_delay, r_cb, r_owner, r_arg, r_id;
    t_result     r_res, n_res;

    // memories
    t_shot r_smem [ONE_SHOT_SLOTS];
    t_slot r_pmem [PERIODIC_SLOTS];
    t_shot r_srd;
    t_slot r_prd;
    logic [SW-1:0] s_raddr, s_waddr;
    logic          s_we;
    t_shot         s_wdata;
    logic [PW-1:0] p_waddr;
    logic          p_we;
    t_slot         p_wdata;

    logic out_free, out_push, in_acc;
    logic [PW-1:0] free_idx;
    logic          free_ok;
    logic [31:0]   iv;
    logic [CW-1:0] k_next;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign k_next     = r_k + CW'(1);
    assign iv         = (r_delay == 32'd0) ? 32'd1 : r_delay;

    // lowest free periodic slot
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int j = PERIODIC_SLOTS - 1; j >= 0; j--) begin
            if (!r_used[j]) begin
                free_idx = PW'(j);
                free_ok  = 1'b1;
            end
        end
    end

    // command latch
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_command;
            r_now   <= i_current_time;
            r_delay <= i_delay;
            r_cb    <= i_callback;
            r_owner <= i_owner_tag;
            r_arg   <= i_user_arg;
            r_id    <= i_timer_id;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_k      = r_k;
        n_count  = r_count;
        n_id_ctr = r_id_ctr;
        n_active = r_active;
        n_used   = r_used;
        n_res    = r_res;
        s_raddr  = r_idx[SW-1:0];
        s_we     = 1'b0;
        s_waddr  = r_k[SW-1:0];
        s_wdata  = r_srd;
        p_we     = 1'b0;
        p_waddr  = r_idx[PW-1:0];
        p_wdata  = r_prd;
        out_push = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx = '0;
                    n_res = '0;
                    case (i_command)
                        CMD_SET_SHOT: begin
                            n_state = ST_SET;
                        end
                        CMD_CANCEL_ID: begin
                            n_res.return_value = ALL_ONES;
                            n_state = ST_S_RD;
                        end
                        CMD_CANCEL_OWNER: begin
                            n_state = ST_S_RD;
                        end
                        CMD_START_PER, CMD_STOP_PER: begin
                            n_res.return_value = ALL_ONES;
                            n_state = ST_P_RD;
                        end
                        CMD_POLL: begin
                            n_state = ST_P_RD;
                        end
                        default: begin
                            n_res.return_value = ALL_ONES;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SET: begin
                logic [31:0] base;
                base = r_active ? r_id_ctr : 32'd0;
                n_active = 1'b1;
                n_id_ctr = base;
                if (r_count < CW'(ONE_SHOT_SLOTS)) begin
                    n_id_ctr = base + 32'd1;
                    s_we     = 1'b1;
                    s_waddr  = r_count[SW-1:0];
                    s_wdata  = '{id: base + 32'd1, owner: r_owner,
                                 deadline: r_now + r_delay, arg: r_arg, callback: r_cb};
                    n_count  = r_count + CW'(1);
                    n_res.return_value = base + 32'd1;
                end else begin
                    n_res.return_value = ALL_ONES;
                end
                n_state = ST_DONE;
            end
            ST_P_RD: begin
                if (r_idx == IW'(PERIODIC_SLOTS)) begin
                    case (r_cmd)
                        CMD_START_PER: n_state = ST_P_NEW;
                        CMD_POLL: begin
                            if (r_count == '0) begin
                                n_active = 1'b0;
                                n_state  = ST_DONE;
                            end else begin
                                n_idx   = '0;
                                n_state = ST_S_RD;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end else begin
                    n_state = ST_P_CHK;
                end
            end
            ST_P_CHK: begin
                n_idx   = r_idx + IW'(1);
                n_state = ST_P_RD;
                if (r_cmd == CMD_POLL) begin
                    if (r_used[r_idx[PW-1:0]] && r_prd.callback != 32'd0 &&
                        reached(r_now, r_prd.due)) begin
                        p_we               = 1'b1;
                        p_wdata.due        = r_now + r_prd.interval;
                        n_res.fired        = 1'b1;
                        n_res.fire_source  = 1'b1;
                        n_res.fire_callback = r_prd.callback;
                        n_res.fire_arg0    = 32'(r_idx);
                        n_state            = ST_DONE;
                    end
                end else if (r_used[r_idx[PW-1:0]] && r_prd.id == r_id) begin
                    n_used[r_idx[PW-1:0]] = 1'b0;
                    if (r_cmd == CMD_STOP_PER) begin
                        n_res.return_value = 32'd0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_P_NEW;
                    end
                end
            end
            ST_P_NEW: begin
                if (free_ok) begin
                    n_used[free_idx] = 1'b1;
                    p_we    = 1'b1;
                    p_waddr = free_idx;
                    p_wdata = '{id: r_id, callback: r_cb, interval: iv, due: r_now + iv};
                    n_res.return_value = 32'(free_idx);
                end
                n_state = ST_DONE;
            end
            ST_S_RD: begin
                if (r_idx < IW'(r_count)) begin
                    n_state = ST_S_CHK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_S_CHK: begin
                n_idx   = r_idx + IW'(1);
                n_k     = r_idx[CW-1:0];
                n_state = ST_S_RD;
                case (r_cmd)
                    CMD_CANCEL_ID: begin
                        if (r_srd.id == r_id) begin
                            n_res.return_value = 32'd0;
                            n_state = ST_SH_RD;
                        end
                    end
                    CMD_CANCEL_OWNER: begin
                        if (r_srd.owner == r_owner) begin
                            n_state = ST_SH_RD;
                        end
                    end
                    default: begin
                        if (reached(r_now, r_srd.deadline)) begin
                            if (r_srd.callback != 32'd0) begin
                                n_res.fired         = 1'b1;
                                n_res.fire_callback = r_srd.callback;
                                n_res.fire_arg0     = r_srd.id;
                                n_res.fire_arg1     = r_srd.arg;
                            end
                            n_state = ST_SH_RD;
                        end
                    end
                endcase
            end
            ST_SH_RD: begin
                s_raddr = k_next[SW-1:0];
                if (k_next < r_count) begin
                    n_state = ST_SH_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = (r_cmd == CMD_CANCEL_OWNER) ? ST_S_RD : ST_DONE;
                end
            end
            ST_SH_WR: begin
                s_we    = 1'b1;
                n_k     = k_next;
                n_state = ST_SH_RD;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_push = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_k      <= '0;
            r_count  <= '0;
            r_id_ctr <= '0;
            r_active <= 1'b0;
            r_used   <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_k      <= n_k;
            r_count  <= n_count;
            r_id_ctr <= n_id_ctr;
            r_active <= n_active;
            r_used   <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // one-shot memory
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_waddr] <= s_wdata;
        end
        r_srd <= r_smem[s_raddr];
    end

    // periodic memory
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pmem[p_waddr] <= p_wdata;
        end
        r_prd <= r_pmem[r_idx[PW-1:0]];
    end

    // output stage
    t_result out_res;

    tmr_tbl_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_res   (r_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_return_value  = out_res.return_value;
    assign o_fired         = out_res.fired;
    assign o_fire_source   = out_res.fire_source;
    assign o_fire_callback = out_res.fire_callback;
    assign o_fire_arg0     = out_res.fire_arg0;
    assign o_fire_arg1     = out_res.fire_arg1;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ONE_SHOT_SLOTS))
        else $error("one-shot count beyond table size");

    a_inactive_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_count == '0))
        else $error("inactive table holds entries");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SH_WR) |-> (k_next < r_count))
        else $error("compaction write beyond table fill");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |=> o_out_valid)
        else $error("result beat lost at output stage");

endmodule
